FILE: hdl/acsp_pkg.sv
// ----------------------------------------------------------------------------
// acsp_pkg
// Shared types, byte codes and the sgr parameter decode for the ansi
// escape sequence parser.
// ----------------------------------------------------------------------------
package acsp_pkg;

   // byte codes
   localparam logic [7:0] ESC_BYTE     = 8'd27;
   localparam logic [7:0] BRACKET_BYTE = 8'h5B;
   localparam logic [7:0] FINAL_LOW    = 8'h41;
   localparam logic [7:0] FINAL_HIGH   = 8'h75;
   localparam logic [7:0] SGR_BYTE     = 8'h6D;
   localparam logic [7:0] SEP_BYTE     = 8'h3B;
   localparam logic [7:0] DIGIT_LOW    = 8'h30;
   localparam logic [7:0] DIGIT_HIGH   = 8'h39;

   // attribute flags
   localparam logic [7:0] AT_BOLD    = 8'h01;
   localparam logic [7:0] AT_UNDER   = 8'h02;
   localparam logic [7:0] AT_ITALIC  = 8'h04;
   localparam logic [7:0] AT_FRAKTUR = 8'h08;
   localparam logic [7:0] AT_BLINK   = 8'h40;
   localparam logic [7:0] AT_CROSS   = 8'h80;

   // reset colours
   localparam logic [4:0] FG_DEFAULT = 5'd7;
   localparam logic [4:0] BG_DEFAULT = 5'd0;

   // parser modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_CSI    = 2'd2;

   // result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_COLOUR = 1'b1;

   // saturation limit of a parameter
   localparam logic [11:0] PARAM_MAX = 12'd255;

   typedef struct packed {
      logic [4:0] fg;
      logic [4:0] bg;
      logic [7:0] attr;
   } colour_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_out;
      logic [4:0] fg_out;
      logic [4:0] bg_out;
      logic [7:0] attr_out;
      logic       last;
   } rsp_type;

   // apply one sgr parameter to a colour set
   function automatic colour_type apply_param(input logic [7:0] v, input colour_type c);
      colour_type r;
      logic [7:0] t;
      r = c;
      t = 8'd0;
      if (v >= 8'd100 && v < 8'd110) begin
         t = v - 8'd92;
         r.bg = t[4:0];
      end else if (v >= 8'd90 && v < 8'd100) begin
         t = v - 8'd82;
         r.fg = t[4:0];
      end else if (v >= 8'd40 && v < 8'd50) begin
         t = v - 8'd40;
         r.bg = t[4:0];
      end else if (v >= 8'd30 && v < 8'd40) begin
         t = v - 8'd30;
         r.fg = t[4:0];
      end else if (v == 8'd20) begin
         r.attr = c.attr | AT_FRAKTUR;
      end else if (v == 8'd9) begin
         r.attr = c.attr | AT_CROSS;
      end else if (v == 8'd7) begin
         r.fg = c.bg;
         r.bg = c.fg;
      end else if (v == 8'd5) begin
         r.attr = c.attr | AT_BLINK;
      end else if (v == 8'd4) begin
         r.attr = c.attr | AT_UNDER;
      end else if (v == 8'd3) begin
         r.attr = c.attr | AT_ITALIC;
      end else if (v == 8'd1) begin
         r.attr = c.attr | AT_BOLD;
      end else if (v == 8'd0) begin
         r.fg   = FG_DEFAULT;
         r.bg   = BG_DEFAULT;
         r.attr = 8'd0;
      end
      return r;
   endfunction

endpackage

FILE: hdl/acsp_decode.sv
// ----------------------------------------------------------------------------
// acsp_decode
// Parser state and per-byte decode: yields up to two results for each
// byte taken and updates the escape, parameter and colour state.
// ----------------------------------------------------------------------------
module acsp_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       byte_in,
   output logic [1:0]       res_count,
   output acsp_pkg::rsp_type res0,
   output acsp_pkg::rsp_type res1
);
   import acsp_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   colour_type  cur_ff, cur_in;
   colour_type  pend_ff, pend_in;
   logic [7:0]  param_ff, param_in;
   logic        token_ff, token_in;
   logic        done_ff, done_in;
   logic        any_ff, any_in;

   logic        is_final;
   logic        is_digit;
   logic [11:0] acc;
   logic [7:0]  digit;
   colour_type  applied;
   logic [7:0]  sel_param;
   colour_type  shown;

   // byte classes and running number
   assign is_final = (byte_in >= FINAL_LOW) && (byte_in <= FINAL_HIGH);
   assign is_digit = (byte_in >= DIGIT_LOW) && (byte_in <= DIGIT_HIGH);
   assign digit    = byte_in - DIGIT_LOW;
   assign acc      = {4'd0, param_ff} * 12'd10 + {4'd0, digit};

   // parameter applied when a token closes: the open one, or a reset
   assign sel_param = token_ff ? param_ff : 8'd0;
   assign applied   = apply_param(sel_param, pend_ff);

   // next state and results
   always_comb begin
      mode_in   = mode_ff;
      cur_in    = cur_ff;
      pend_in   = pend_ff;
      param_in  = param_ff;
      token_in  = token_ff;
      done_in   = done_ff;
      any_in    = any_ff;
      res_count = 2'd0;
      res0      = '0;
      res1      = '0;
      shown     = cur_ff;
      case (mode_ff)
         MODE_ESC: begin
            if (byte_in == BRACKET_BYTE) begin
               mode_in  = MODE_CSI;
               pend_in  = cur_ff;
               param_in = 8'd0;
               token_in = 1'b0;
               done_in  = 1'b0;
               any_in   = 1'b0;
            end else begin
               mode_in       = MODE_NORMAL;
               res_count     = 2'd2;
               res0.kind     = KIND_CHAR;
               res0.char_out = ESC_BYTE;
               res1.kind     = KIND_CHAR;
               res1.char_out = byte_in;
               res1.last     = 1'b1;
            end
         end
         MODE_CSI: begin
            if (is_final) begin
               if (byte_in == SGR_BYTE) begin
                  if (token_ff || !any_ff) begin
                     cur_in = applied;
                  end else begin
                     cur_in = pend_ff;
                  end
               end
               param_in = 8'd0;
               token_in = 1'b0;
               done_in  = 1'b0;
               any_in   = 1'b0;
               mode_in  = MODE_NORMAL;
               // colour update reflects the committed colours
               shown         = cur_in;
               res_count     = 2'd1;
               res0.kind     = KIND_COLOUR;
               res0.char_out = byte_in;
               res0.fg_out   = ((shown.attr & AT_BOLD) != 8'd0) ?
                               {2'b01, shown.fg[2:0]} : shown.fg;
               res0.bg_out   = shown.bg;
               res0.attr_out = shown.attr;
               res0.last     = 1'b1;
            end else if (byte_in == SEP_BYTE) begin
               if (token_ff) begin
                  pend_in = applied;
                  any_in  = 1'b1;
               end
               token_in = 1'b0;
               done_in  = 1'b0;
               param_in = 8'd0;
            end else begin
               token_in = 1'b1;
               if (is_digit) begin
                  if (!done_ff) begin
                     param_in = (acc > PARAM_MAX) ? PARAM_MAX[7:0] : acc[7:0];
                  end
               end else begin
                  done_in = 1'b1;
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (byte_in == ESC_BYTE) begin
               mode_in = MODE_ESC;
            end else begin
               res_count     = 2'd1;
               res0.kind     = KIND_CHAR;
               res0.char_out = byte_in;
               res0.last     = 1'b1;
            end
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         cur_ff   <= '{fg: FG_DEFAULT, bg: BG_DEFAULT, attr: 8'd0};
         pend_ff  <= '{fg: FG_DEFAULT, bg: BG_DEFAULT, attr: 8'd0};
         param_ff <= 8'd0;
         token_ff <= 1'b0;
         done_ff  <= 1'b0;
         any_ff   <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         cur_ff   <= cur_in;
         pend_ff  <= pend_in;
         param_ff <= param_in;
         token_ff <= token_in;
         done_ff  <= done_in;
         any_ff   <= any_in;
      end
   end

endmodule

FILE: hdl/ansi_csi_sgr_parser_unit.sv
// ----------------------------------------------------------------------------
// ansi_csi_sgr_parser_unit
// Byte stream decoder for ansi csi / sgr escape sequences.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one terminal output byte per transfer (req_byte_in).
//   rsp channel: characters to write (kind 0) and colour updates (kind 1);
//     rsp_last marks the final result caused by one request byte.
//   A byte is decoded in the cycle it is taken and its results are written
//   to a four-entry result queue; when the queue was empty, the first result
//   is offered on rsp the next cycle.
//   Throughput: one byte per cycle while results drain at one per cycle;
//   a byte that yields two results (ESC followed by anything but '[')
//   needs two rsp transfers, so the rsp port sets the sustained rate.
//   req_stall rises when the queue has room for fewer than two results,
//   so rsp_stall backs up into req once three or more results are queued.
//   Reset empties the queue, returns to normal mode and sets the colours
//   to foreground 7, background 0, no attributes.
//   A stalled result holds on rsp until it is taken.
// ----------------------------------------------------------------------------
module ansi_csi_sgr_parser_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic [4:0] rsp_fg_out,
   output logic [4:0] rsp_bg_out,
   output logic [7:0] rsp_attr_out,
   output logic       rsp_last
);
   import acsp_pkg::*;

   logic       req_take;
   logic       rsp_take;
   logic [1:0] res_count;
   rsp_type    res0;
   rsp_type    res1;

   rsp_type    queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_next;
   logic [2:0] push_n;
   rsp_type    head;

   assign req_stall = (count_ff > 3'd2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // byte decode
   acsp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .byte_in   (req_byte_in),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   // queue pointer and fill update
   assign wr_next = wr_ptr_ff + 2'd1;
   assign push_n  = req_take ? {1'b0, res_count} : 3'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[1:0];
      rd_ptr_in = rsp_take ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + push_n - (rsp_take ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_n != 3'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 3'd2) begin
         queue_ff[wr_next] <= res1;
      end
   end

   // head of queue drives rsp
   assign head         = queue_ff[rd_ptr_ff];
   assign rsp_kind     = head.kind;
   assign rsp_char_out = head.char_out;
   assign rsp_fg_out   = head.fg_out;
   assign rsp_bg_out   = head.bg_out;
   assign rsp_attr_out = head.attr_out;
   assign rsp_last     = head.last;

endmodule
